/* rtl/stg_pkg.sv */
package stg_pkg;

    // Angle constants in Q16.16 radians.
    localparam int ZW = 22;
    localparam logic signed [ZW-1:0] Q_PI      = 22'sd205887;
    localparam logic signed [ZW-1:0] Q_HALF_PI = 22'sd102944;
    localparam logic signed [ZW-1:0] Q_TWO_PI  = 22'sd411775;

    // CORDIC datapath widths and constants.
    localparam int CW = 45;
    localparam int VW = 36;
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [CW-1:0] NORM_LIMIT = 45'sh100_0000_0000;
    localparam logic signed [CW-1:0] CORDIC_X0  = 45'sd652034048;
    localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
    };

    // CORDIC operating modes.
    localparam logic CM_VEC = 1'b0;
    localparam logic CM_ROT = 1'b1;

    // Turn-rate sample grid, w_k = round((k - 20) * 65536 / 10).
    localparam int GRID_MAX    = 129;
    localparam int GRID_IW     = 8;
    localparam int GRID_OFFSET = 20;
    localparam int WW          = 21;
    typedef logic signed [WW-1:0] grid_tab_t [GRID_MAX];

    function automatic grid_tab_t grid_build();
        grid_tab_t t;
        longint    num;
        for (int k = 0; k < GRID_MAX; k++) begin
            num = longint'(k - GRID_OFFSET) * 65536;
            if (num >= 0) begin
                t[k] = WW'((num + 5) / 10);
            end else begin
                t[k] = WW'(-((-num + 5) / 10));
            end
        end
        return t;
    endfunction

    localparam grid_tab_t GRID_TAB = grid_build();

    // Register indexes.
    localparam logic [2:0] REG_GOAL_X     = 3'd0;
    localparam logic [2:0] REG_GOAL_Y     = 3'd1;
    localparam logic [2:0] REG_OBS_X      = 3'd2;
    localparam logic [2:0] REG_OBS_Y      = 3'd3;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd4;
    localparam logic [2:0] REG_OBS_RADIUS = 3'd5;
    localparam logic [2:0] REG_HEAD_LIMIT = 3'd6;
    localparam logic [2:0] REG_ARRIVE_RAD = 3'd7;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic signed [27:0] goal_x;
        logic signed [27:0] goal_y;
        logic signed [27:0] obs_x;
        logic signed [27:0] obs_y;
        logic [18:0]        max_speed;
        logic [20:0]        obs_radius;
        logic [17:0]        heading_limit;
        logic [20:0]        arrive_radius;
    } cfg_t;

endpackage

/* rtl/stg_regs.sv */
module stg_regs
    import stg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        disarm,
    output cfg_t        cfg,
    output logic        armed
);

    cfg_t cfg_reg;
    logic armed_reg;
    logic wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign armed  = armed_reg;

    // Register writes; a goal write arms the block, arrival disarms it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_x        <= '0;
            cfg_reg.goal_y        <= '0;
            cfg_reg.obs_x         <= -28'sd6553600;
            cfg_reg.obs_y         <= -28'sd6553600;
            cfg_reg.max_speed     <= 19'd32768;
            cfg_reg.obs_radius    <= 21'd65536;
            cfg_reg.heading_limit <= 18'd32768;
            cfg_reg.arrive_radius <= 21'd6554;
            armed_reg             <= 1'b0;
        end else begin
            if (disarm) begin
                armed_reg <= 1'b0;
            end
            if (wr_en) begin
                unique case (paddr[4:2])
                    REG_GOAL_X: begin
                        cfg_reg.goal_x <= pwdata[27:0];
                        armed_reg      <= 1'b1;
                    end
                    REG_GOAL_Y: begin
                        cfg_reg.goal_y <= pwdata[27:0];
                        armed_reg      <= 1'b1;
                    end
                    REG_OBS_X:      cfg_reg.obs_x         <= pwdata[27:0];
                    REG_OBS_Y:      cfg_reg.obs_y         <= pwdata[27:0];
                    REG_MAX_SPEED:  cfg_reg.max_speed     <= pwdata[18:0];
                    REG_OBS_RADIUS: cfg_reg.obs_radius    <= pwdata[20:0];
                    REG_HEAD_LIMIT: cfg_reg.heading_limit <= pwdata[17:0];
                    REG_ARRIVE_RAD: cfg_reg.arrive_radius <= pwdata[20:0];
                endcase
            end
        end
    end

    // Read mux.
    always_comb begin
        unique case (paddr[4:2])
            REG_GOAL_X:     prdata = 32'(cfg_reg.goal_x);
            REG_GOAL_Y:     prdata = 32'(cfg_reg.goal_y);
            REG_OBS_X:      prdata = 32'(cfg_reg.obs_x);
            REG_OBS_Y:      prdata = 32'(cfg_reg.obs_y);
            REG_MAX_SPEED:  prdata = 32'(cfg_reg.max_speed);
            REG_OBS_RADIUS: prdata = 32'(cfg_reg.obs_radius);
            REG_HEAD_LIMIT: prdata = 32'(cfg_reg.heading_limit);
            REG_ARRIVE_RAD: prdata = 32'(cfg_reg.arrive_radius);
        endcase
    end

endmodule

/* rtl/stg_isqrt.sv */
module stg_isqrt
    import stg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [57:0] in_n,
    output logic        done,
    output logic [28:0] root
);

    localparam logic [1:0] Q_IDLE = 2'd0;
    localparam logic [1:0] Q_RUN  = 2'd1;
    localparam logic [1:0] Q_DONE = 2'd2;

    logic [1:0]  state_reg;
    logic [57:0] n_reg;
    logic [57:0] r_reg;
    logic [57:0] b_reg;
    logic [57:0] trial;

    assign trial = r_reg + b_reg;
    assign done  = (state_reg == Q_DONE);
    assign root  = r_reg[28:0];

    // One result bit per cycle, bit pairs from the top down.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= Q_IDLE;
        end else begin
            unique case (state_reg)
                Q_IDLE: begin
                    if (start) begin
                        n_reg     <= in_n;
                        r_reg     <= '0;
                        b_reg     <= 58'd1 << 56;
                        state_reg <= Q_RUN;
                    end
                end
                Q_RUN: begin
                    if (n_reg >= trial) begin
                        n_reg <= n_reg - trial;
                        r_reg <= (r_reg >> 1) + b_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    b_reg <= b_reg >> 2;
                    if (b_reg == 58'd1) begin
                        state_reg <= Q_DONE;
                    end
                end
                Q_DONE: state_reg <= Q_IDLE;
                default: state_reg <= Q_IDLE;
            endcase
        end
    end

endmodule

/* rtl/stg_cordic.sv */
module stg_cordic
    import stg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 mode,
    input  logic signed [VW-1:0] in_x,
    input  logic signed [VW-1:0] in_y,
    input  logic signed [ZW-1:0] in_ang,
    output logic                 done,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic signed [ZW-1:0] out_ang
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_WRAP = 3'd1;
    localparam logic [2:0] C_NORM = 3'd2;
    localparam logic [2:0] C_ITER = 3'd3;
    localparam logic [2:0] C_DONE = 3'd4;

    logic [2:0]           state_reg;
    logic                 mode_reg;
    logic                 neg_reg;
    logic [3:0]           i_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [ZW-1:0] tab;

    assign xs  = CW'(in_x);
    assign ys  = CW'(in_y);
    assign ax  = x_reg[CW-1] ? -x_reg : x_reg;
    assign ay  = y_reg[CW-1] ? -y_reg : y_reg;
    assign sx  = y_reg >>> i_reg;
    assign sy  = x_reg >>> i_reg;
    assign tab = ZW'(ATAN_TAB[i_reg]);

    assign done    = (state_reg == C_DONE);
    assign out_x   = neg_reg ? -x_reg : x_reg;
    assign out_y   = neg_reg ? -y_reg : y_reg;
    assign out_ang = z_reg;

    // Sequencer: pre-rotate and normalize (vectoring) or wrap (rotation), then one micro-rotation a cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        mode_reg <= mode;
                        neg_reg  <= 1'b0;
                        i_reg    <= '0;
                        if (mode == CM_ROT) begin
                            x_reg     <= CORDIC_X0;
                            y_reg     <= '0;
                            z_reg     <= in_ang;
                            state_reg <= C_WRAP;
                        end else if (in_x == '0 && in_y == '0) begin
                            x_reg     <= '0;
                            y_reg     <= '0;
                            z_reg     <= '0;
                            state_reg <= C_DONE;
                        end else begin
                            state_reg <= C_NORM;
                            if (in_x < 0) begin
                                if (in_y >= 0) begin
                                    x_reg <= ys;
                                    y_reg <= -xs;
                                    z_reg <= Q_HALF_PI;
                                end else begin
                                    x_reg <= -ys;
                                    y_reg <= xs;
                                    z_reg <= -Q_HALF_PI;
                                end
                            end else begin
                                x_reg <= xs;
                                y_reg <= ys;
                                z_reg <= '0;
                            end
                        end
                    end
                end
                C_WRAP: begin
                    if (z_reg > Q_PI) begin
                        z_reg <= z_reg - Q_TWO_PI;
                    end else if (z_reg < -Q_PI) begin
                        z_reg <= z_reg + Q_TWO_PI;
                    end else if (z_reg > Q_HALF_PI) begin
                        z_reg     <= z_reg - Q_PI;
                        neg_reg   <= 1'b1;
                        state_reg <= C_ITER;
                    end else if (z_reg < -Q_HALF_PI) begin
                        z_reg     <= z_reg + Q_PI;
                        neg_reg   <= 1'b1;
                        state_reg <= C_ITER;
                    end else begin
                        state_reg <= C_ITER;
                    end
                end
                C_NORM: begin
                    if (ax < NORM_LIMIT && ay < NORM_LIMIT) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end else begin
                        state_reg <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (mode_reg == CM_VEC) begin
                        if (y_reg > 0) begin
                            x_reg <= x_reg + sx;
                            y_reg <= y_reg - sy;
                            z_reg <= z_reg + tab;
                        end else begin
                            x_reg <= x_reg - sx;
                            y_reg <= y_reg + sy;
                            z_reg <= z_reg - tab;
                        end
                    end else begin
                        if (z_reg >= 0) begin
                            x_reg <= x_reg - sx;
                            y_reg <= y_reg + sy;
                            z_reg <= z_reg - tab;
                        end else begin
                            x_reg <= x_reg + sx;
                            y_reg <= y_reg - sy;
                            z_reg <= z_reg + tab;
                        end
                    end
                    i_reg <= i_reg + 4'd1;
                    if (i_reg == 4'(CORDIC_STEPS - 1)) begin
                        state_reg <= C_DONE;
                    end
                end
                C_DONE: state_reg <= C_IDLE;
                default: state_reg <= C_IDLE;
            endcase
        end
    end

endmodule

/* rtl/sampled_turn_rate_goal_steering.sv */
// An armed item passes through the quaternion products, square root, yaw, speed and
// per-sample search, plus any wait for the output register; an item taken while
// unarmed gives no result.
// One item at a time; the per-sample CORDIC rotation and the six products through
// the one shared multiplier make up most of the work.
// Reset (aresetn, synchronous, active low) leaves the block unarmed and the
// registers at their defaults.
module sampled_turn_rate_goal_steering
    import stg_pkg::*;
#(
    parameter int SAMPLE_COUNT = 41
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [27:0] s_pos_x,
    input  logic signed [27:0] s_pos_y,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [18:0]        m_linear_speed,
    output logic signed [18:0] m_turn_rate,
    output logic               m_goal_reached,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int KW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(SAMPLE_COUNT - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PRE  = 4'd1;
    localparam logic [3:0] ST_SQRT = 4'd2;
    localparam logic [3:0] ST_YAW  = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_SROT = 4'd5;
    localparam logic [3:0] ST_SMUL = 4'd6;
    localparam logic [3:0] ST_HEAD = 4'd7;
    localparam logic [3:0] ST_WRAP = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    localparam logic signed [32:0] RECIP_5 = 33'sh0_CCCC_CCCD;
    localparam logic signed [WW-1:0] TURN_MAX = 21'sd262143;
    localparam logic signed [WW-1:0] TURN_MIN = -21'sd262144;

    // Configuration registers.
    cfg_t cfg;
    logic armed;
    logic disarm;

    stg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .disarm  (disarm),
        .cfg     (cfg),
        .armed   (armed)
    );

    // Control and datapath state.
    logic [3:0]           state_reg;
    logic                 phase_reg;
    logic [3:0]           op_reg;
    logic [KW-1:0]        k_reg;
    logic signed [27:0]   px_reg, py_reg;
    logic signed [15:0]   qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [28:0]   dx_reg, dy_reg;
    logic signed [VW-1:0] acc_d_reg, acc_yz_reg, acc_m_reg, acc_n_reg;
    logic [57:0]          d2_reg;
    logic [41:0]          r2_reg, a2_reg;
    logic [18:0]          v_reg;
    logic signed [ZW-1:0] yaw_reg, err_reg;
    logic signed [32:0]   c_reg, s_reg;
    logic signed [28:0]   fx_reg, fy_reg;
    logic [58:0]          o2_reg, g2_reg, best_d2_reg;
    logic signed [WW-1:0] best_w_reg;
    logic                 found_reg;
    logic                 hbad_reg;
    logic signed [65:0]   prod_reg;
    logic                 m_valid_reg;
    logic [18:0]          m_speed_reg;
    logic signed [18:0]   m_turn_reg;
    logic                 m_reached_reg;

    // Shared CORDIC unit and the square-root unit.
    logic                 cor_start, cor_mode, cor_done;
    logic signed [VW-1:0] cor_x, cor_y;
    logic signed [ZW-1:0] cor_ang, cor_z;
    logic signed [CW-1:0] cor_ox, cor_oy;
    logic                 sq_start, sq_done;
    logic [28:0]          sq_root;

    stg_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .mode    (cor_mode),
        .in_x    (cor_x),
        .in_y    (cor_y),
        .in_ang  (cor_ang),
        .done    (cor_done),
        .out_x   (cor_ox),
        .out_y   (cor_oy),
        .out_ang (cor_z)
    );

    stg_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .in_n    (d2_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    // Derived values.
    logic signed [WW-1:0] w_cur;
    logic signed [29:0]   ox, oy, gx, gy;
    logic [VW:0]          abs_m2;
    logic                 degen;
    logic signed [VW-1:0] yaw_x, yaw_y;
    logic [32:0]          n3;
    logic [28:0]          quot;
    logic [58:0]          g2_sum;
    logic                 blocked;
    logic [ZW-1:0]        err_abs;
    logic                 arrived;
    logic                 out_free;
    logic signed [32:0]   mul_a, mul_b;

    assign w_cur   = GRID_TAB[GRID_IW'(k_reg)];
    assign ox      = 30'(cfg.obs_x) - 30'(fx_reg);
    assign oy      = 30'(cfg.obs_y) - 30'(fy_reg);
    assign gx      = 30'(cfg.goal_x) - 30'(fx_reg);
    assign gy      = 30'(cfg.goal_y) - 30'(fy_reg);
    assign abs_m2  = acc_m_reg[VW-1] ? (VW+1)'(-acc_m_reg) << 1 : (VW+1)'(acc_m_reg) << 1;
    assign degen   = abs_m2 >= (VW+1)'(acc_d_reg);
    assign yaw_x   = acc_d_reg - (acc_yz_reg <<< 1);
    assign yaw_y   = acc_n_reg <<< 1;
    assign n3      = 33'({sq_root, 1'b0}) + 33'(sq_root);
    assign quot    = prod_reg[62:34];
    assign g2_sum  = g2_reg + 59'(prod_reg[57:0]);
    assign blocked = o2_reg < 59'(r2_reg);
    assign err_abs = err_reg[ZW-1] ? ZW'(-err_reg) : ZW'(err_reg);
    assign arrived = d2_reg <= 58'(a2_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign disarm  = (state_reg == ST_DONE) && out_free && arrived;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_linear_speed = m_speed_reg;
    assign m_turn_rate    = m_turn_reg;
    assign m_goal_reached = m_reached_reg;

    // Unit start strobes on the first cycle of each waiting state.
    assign sq_start  = (state_reg == ST_SQRT) && !phase_reg;
    assign cor_start = !phase_reg && (((state_reg == ST_YAW) && !degen) ||
                       (state_reg == ST_SROT) || (state_reg == ST_HEAD));

    // CORDIC operand selection.
    always_comb begin
        cor_mode = CM_VEC;
        cor_x    = yaw_x;
        cor_y    = yaw_y;
        cor_ang  = yaw_reg + ZW'(w_cur >>> 1);
        case (state_reg)
            ST_HEAD: begin
                cor_x = VW'(dx_reg);
                cor_y = VW'(dy_reg);
            end
            ST_SROT: cor_mode = CM_ROT;
            default: ;
        endcase
    end

    // Multiplier operand selection by step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PRE: begin
                case (op_reg)
                    4'd0: begin mul_a = 33'(qx_reg); mul_b = 33'(qx_reg); end
                    4'd1: begin mul_a = 33'(qy_reg); mul_b = 33'(qy_reg); end
                    4'd2: begin mul_a = 33'(qz_reg); mul_b = 33'(qz_reg); end
                    4'd3: begin mul_a = 33'(qw_reg); mul_b = 33'(qw_reg); end
                    4'd4: begin mul_a = 33'(qx_reg); mul_b = 33'(qz_reg); end
                    4'd5: begin mul_a = 33'(qw_reg); mul_b = 33'(qy_reg); end
                    4'd6: begin mul_a = 33'(qx_reg); mul_b = 33'(qy_reg); end
                    4'd7: begin mul_a = 33'(qw_reg); mul_b = 33'(qz_reg); end
                    4'd8: begin mul_a = 33'(dx_reg); mul_b = 33'(dx_reg); end
                    4'd9: begin mul_a = 33'(dy_reg); mul_b = 33'(dy_reg); end
                    4'd10: begin
                        mul_a = 33'(cfg.obs_radius);
                        mul_b = 33'(cfg.obs_radius);
                    end
                    default: begin
                        mul_a = 33'(cfg.arrive_radius);
                        mul_b = 33'(cfg.arrive_radius);
                    end
                endcase
            end
            ST_DIV: begin
                mul_a = n3;
                mul_b = RECIP_5;
            end
            ST_SMUL: begin
                case (op_reg)
                    4'd0: begin mul_a = 33'(v_reg); mul_b = c_reg; end
                    4'd1: begin mul_a = 33'(v_reg); mul_b = s_reg; end
                    4'd2: begin mul_a = 33'(ox); mul_b = 33'(ox); end
                    4'd3: begin mul_a = 33'(oy); mul_b = 33'(oy); end
                    4'd4: begin mul_a = 33'(gx); mul_b = 33'(gx); end
                    default: begin mul_a = 33'(gy); mul_b = 33'(gy); end
                endcase
            end
            default: ;
        endcase
    end

    // Product register of the shared multiplier.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Main sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            op_reg      <= '0;
            k_reg       <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        px_reg    <= s_pos_x;
                        py_reg    <= s_pos_y;
                        qx_reg    <= s_quat_x;
                        qy_reg    <= s_quat_y;
                        qz_reg    <= s_quat_z;
                        qw_reg    <= s_quat_w;
                        dx_reg    <= 29'(cfg.goal_x) - 29'(s_pos_x);
                        dy_reg    <= 29'(cfg.goal_y) - 29'(s_pos_y);
                        op_reg    <= '0;
                        phase_reg <= 1'b0;
                        if (armed) begin
                            state_reg <= ST_PRE;
                        end
                    end
                end
                // Quaternion terms, goal distance and radius squares.
                ST_PRE: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        op_reg <= op_reg + 4'd1;
                        case (op_reg)
                            4'd0: acc_d_reg <= $signed(prod_reg[VW-1:0]);
                            4'd1: begin
                                acc_d_reg  <= acc_d_reg + $signed(prod_reg[VW-1:0]);
                                acc_yz_reg <= $signed(prod_reg[VW-1:0]);
                            end
                            4'd2: begin
                                acc_d_reg  <= acc_d_reg + $signed(prod_reg[VW-1:0]);
                                acc_yz_reg <= acc_yz_reg + $signed(prod_reg[VW-1:0]);
                            end
                            4'd3: acc_d_reg <= acc_d_reg + $signed(prod_reg[VW-1:0]);
                            4'd4: acc_m_reg <= $signed(prod_reg[VW-1:0]);
                            4'd5: acc_m_reg <= acc_m_reg - $signed(prod_reg[VW-1:0]);
                            4'd6: acc_n_reg <= $signed(prod_reg[VW-1:0]);
                            4'd7: acc_n_reg <= acc_n_reg + $signed(prod_reg[VW-1:0]);
                            4'd8: d2_reg <= prod_reg[57:0];
                            4'd9: d2_reg <= d2_reg + prod_reg[57:0];
                            4'd10: r2_reg <= prod_reg[41:0];
                            default: begin
                                a2_reg    <= prod_reg[41:0];
                                state_reg <= ST_SQRT;
                            end
                        endcase
                    end
                end
                ST_SQRT: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else if (sq_done) begin
                        phase_reg <= 1'b0;
                        state_reg <= ST_YAW;
                    end
                end
                // Yaw from the quaternion; degenerate orientations give zero.
                ST_YAW: begin
                    if (!phase_reg) begin
                        if (degen) begin
                            yaw_reg   <= '0;
                            state_reg <= ST_DIV;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end else if (cor_done) begin
                        yaw_reg   <= cor_z;
                        phase_reg <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end
                // Speed is 3/5 of the distance, capped.
                ST_DIV: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        v_reg      <= (quot > 29'(cfg.max_speed)) ? cfg.max_speed : quot[18:0];
                        k_reg      <= '0;
                        found_reg  <= 1'b0;
                        best_w_reg <= '0;
                        state_reg  <= ST_SROT;
                    end
                end
                ST_SROT: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else if (cor_done) begin
                        c_reg     <= cor_ox[32:0];
                        s_reg     <= cor_oy[32:0];
                        phase_reg <= 1'b0;
                        op_reg    <= '0;
                        state_reg <= ST_SMUL;
                    end
                end
                // Predicted position, obstacle test and goal distance for one sample.
                ST_SMUL: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        op_reg <= op_reg + 4'd1;
                        case (op_reg)
                            4'd0: fx_reg <= 29'(px_reg) + 29'($signed(prod_reg[51:30]));
                            4'd1: fy_reg <= 29'(py_reg) + 29'($signed(prod_reg[51:30]));
                            4'd2: o2_reg <= 59'(prod_reg[57:0]);
                            4'd3: o2_reg <= o2_reg + 59'(prod_reg[57:0]);
                            4'd4: g2_reg <= 59'(prod_reg[57:0]);
                            default: begin
                                if (!blocked && (!found_reg || g2_sum < best_d2_reg)) begin
                                    found_reg   <= 1'b1;
                                    best_d2_reg <= g2_sum;
                                    best_w_reg  <= w_cur;
                                end
                                k_reg <= k_reg + 1'b1;
                                if (k_reg == K_LAST) begin
                                    state_reg <= ST_HEAD;
                                end else begin
                                    state_reg <= ST_SROT;
                                end
                            end
                        endcase
                    end
                end
                ST_HEAD: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else if (cor_done) begin
                        err_reg   <= cor_z - yaw_reg;
                        phase_reg <= 1'b0;
                        state_reg <= ST_WRAP;
                    end
                end
                // Wrap the heading error and test it against the limit.
                ST_WRAP: begin
                    if (err_reg > Q_PI) begin
                        err_reg <= err_reg - Q_TWO_PI;
                    end else if (err_reg < -Q_PI) begin
                        err_reg <= err_reg + Q_TWO_PI;
                    end else begin
                        hbad_reg  <= err_abs > ZW'(cfg.heading_limit);
                        state_reg <= ST_DONE;
                    end
                end
                // Load the result once the output register is free.
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        if (arrived) begin
                            m_speed_reg   <= '0;
                            m_turn_reg    <= '0;
                            m_reached_reg <= 1'b1;
                        end else begin
                            m_speed_reg   <= hbad_reg ? '0 : v_reg;
                            m_reached_reg <= 1'b0;
                            if (best_w_reg > TURN_MAX) begin
                                m_turn_reg <= 19'(TURN_MAX);
                            end else if (best_w_reg < TURN_MIN) begin
                                m_turn_reg <= 19'(TURN_MIN);
                            end else begin
                                m_turn_reg <= 19'(best_w_reg);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* verif/sampled_turn_rate_goal_steering_tb.sv */
module sampled_turn_rate_goal_steering_tb;
    import stg_pkg::*;

    localparam int  PERIOD      = 4;
    localparam int  SAMPLES     = 41;
    localparam int  MID_SAMPLE  = 20;
    localparam longint ANG_PI      = 205887;
    localparam longint ANG_HALF_PI = 102944;
    localparam longint ANG_TWO_PI  = 411775;
    localparam longint UNIT_X0     = 64'sd39797 * 16384;
    localparam longint NORM_FLOOR  = 64'sd1 << 40;
    localparam longint TURN_HI     = 262143;
    localparam longint TURN_LO     = -262144;
    localparam longint POS_HI      = 134217727;
    localparam longint POS_LO      = -134217728;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     DRAIN_WAIT  = 64;
    localparam longint ARCTAN [16] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        logic signed [27:0] px;
        logic signed [27:0] py;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } pose_t;

    typedef struct {
        logic [18:0]        speed;
        logic signed [18:0] turn;
        logic               reached;
    } steer_cmd_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [27:0] s_pos_x = '0;
    logic signed [27:0] s_pos_y = '0;
    logic signed [15:0] s_quat_x = '0;
    logic signed [15:0] s_quat_y = '0;
    logic signed [15:0] s_quat_z = '0;
    logic signed [15:0] s_quat_w = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [18:0]        m_linear_speed;
    logic signed [18:0] m_turn_rate;
    logic               m_goal_reached;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    sampled_turn_rate_goal_steering i_dut (.*);

    // Shadow copy of the registers and the arm flag.
    longint goal_x, goal_y, obst_x, obst_y;
    longint speed_cap, obst_radius, head_limit, arrive_rad;
    bit     armed;

    steer_cmd_t pending_cmds[$];
    int         errors = 0;
    longint     cycles = 0;
    int         burst_left = 0;

    // Clock generation.
    initial begin
        forever #(PERIOD / 2) aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint sign_ext(longint unsigned v, int w);
        longint unsigned m;
        m = (64'd1 << w) - 1;
        v &= m;
        if (v[w-1]) return longint'(v) - longint'(64'd1 << w);
        return longint'(v);
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint wrap_pi(longint a);
        while (a > ANG_PI) a -= ANG_TWO_PI;
        while (a < -ANG_PI) a += ANG_TWO_PI;
        return a;
    endfunction

    // Vectoring CORDIC: angle of (x, y).
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, mag, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = ANG_HALF_PI;
            end else begin
                x = -y; y = t; z = -ANG_HALF_PI;
            end
        end
        mag = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
        while (mag < NORM_FLOOR) begin
            x *= 2; y *= 2; mag *= 2;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ARCTAN[i];
            end else begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
        end
        return z;
    endfunction

    // Rotation CORDIC: cosine and sine in Q2.30.
    function automatic void unit_rotate(input longint a, output longint c, output longint s);
        longint x, y, nx, dx, dy;
        bit     flip;
        x = UNIT_X0;
        y = 0;
        flip = 0;
        a = wrap_pi(a);
        if (a > ANG_HALF_PI) begin
            a -= ANG_PI; flip = 1;
        end else if (a < -ANG_HALF_PI) begin
            a += ANG_PI; flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                nx = x - dx; y += dy; a -= ARCTAN[i];
            end else begin
                nx = x + dx; y -= dy; a += ARCTAN[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint pose_yaw(pose_t p);
        longint qx, qy, qz, qw, d, m20;
        qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
        d = qx * qx + qy * qy + qz * qz + qw * qw;
        m20 = 2 * (qx * qz - qw * qy);
        if (abs64(m20) >= d) return 0;
        return vector_angle(2 * (qx * qy + qw * qz), d - 2 * (qy * qy + qz * qz));
    endfunction

    function automatic longint sample_rate(int k);
        longint num;
        num = longint'(k - MID_SAMPLE) * 65536;
        if (num >= 0) return (num + 5) / 10;
        return -((-num + 5) / 10);
    endfunction

    // Steering command for one pose; returns 0 when the block stays silent.
    function automatic bit steer_predict(input pose_t p, output steer_cmd_t cmd);
        longint px, py, yaw, dx, dy, v, best_w, err, r2, w, c, s, fx, fy, ox, oy, gx, gy;
        longint unsigned d2, g2, best_g2;
        bit found;
        cmd = '{default: '0};
        if (!armed) return 0;
        px = p.px;
        py = p.py;
        yaw = pose_yaw(p);
        dx = goal_x - px;
        dy = goal_y - py;
        d2 = longint'(dx * dx) + longint'(dy * dy);
        v = longint'(floor_sqrt(d2)) * 3 / 5;
        if (v > speed_cap) v = speed_cap;
        r2 = obst_radius * obst_radius;
        found = 0;
        best_w = 0;
        best_g2 = 0;
        for (int k = 0; k < SAMPLES; k++) begin
            w = sample_rate(k);
            unit_rotate(yaw + (w >>> 1), c, s);
            fx = px + ((v * c) >>> 30);
            fy = py + ((v * s) >>> 30);
            ox = obst_x - fx;
            oy = obst_y - fy;
            if (ox * ox + oy * oy < r2) continue;
            gx = goal_x - fx;
            gy = goal_y - fy;
            g2 = longint'(gx * gx) + longint'(gy * gy);
            if (!found || g2 < best_g2) begin
                found = 1;
                best_g2 = g2;
                best_w = w;
            end
        end
        err = wrap_pi(vector_angle(dy, dx) - yaw);
        if (abs64(err) > head_limit) v = 0;
        if (d2 > longint'(arrive_rad * arrive_rad)) begin
            if (best_w > TURN_HI) best_w = TURN_HI;
            if (best_w < TURN_LO) best_w = TURN_LO;
            cmd.speed = v[18:0];
            cmd.turn = best_w[18:0];
            cmd.reached = 1'b0;
        end else begin
            cmd.reached = 1'b1;
            armed = 0;
        end
        return 1;
    endfunction

    function automatic void shadow_write(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_GOAL_X: begin
                goal_x = sign_ext(val, 28); armed = 1;
            end
            REG_GOAL_Y: begin
                goal_y = sign_ext(val, 28); armed = 1;
            end
            REG_OBS_X:      obst_x = sign_ext(val, 28);
            REG_OBS_Y:      obst_y = sign_ext(val, 28);
            REG_MAX_SPEED:  speed_cap = val & 32'h7FFFF;
            REG_OBS_RADIUS: obst_radius = val & 32'h1FFFFF;
            REG_HEAD_LIMIT: head_limit = val & 32'h3FFFF;
            REG_ARRIVE_RAD: arrive_rad = val & 32'h1FFFFF;
            default: ;
        endcase
    endfunction

    // Register write over the configuration port: setup, then access.
    task automatic write_reg(logic [2:0] idx, longint val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val[31:0];
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        shadow_write(idx, val[31:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits for every expected command, then lets an ignored pose finish.
    task automatic wait_drained();
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Sends one pose transaction; bursts and gaps are decided here.
    task automatic send_pose(pose_t p);
        steer_cmd_t cmd;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_pos_x <= p.px;
        s_pos_y <= p.py;
        s_quat_x <= p.qx;
        s_quat_y <= p.qy;
        s_quat_z <= p.qz;
        s_quat_w <= p.qw;
        do @(posedge aclk); while (!s_ready);
        if (steer_predict(p, cmd)) pending_cmds.push_back(cmd);
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic longint clamp_pos(longint v);
        return v > POS_HI ? POS_HI : (v < POS_LO ? POS_LO : v);
    endfunction

    function automatic pose_t make_pose(longint x, longint y, longint qx, longint qy,
                                        longint qz, longint qw);
        pose_t p;
        p.px = x; p.py = y;
        p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
        return p;
    endfunction

    // Pose near the goal, mostly a planar rotation about z.
    function automatic pose_t near_pose(longint span);
        longint ox, oy;
        ox = longint'($urandom_range(0, 2 * span)) - span;
        oy = longint'($urandom_range(0, 2 * span)) - span;
        if ($urandom_range(0, 4) == 0) begin
            return make_pose(clamp_pos(goal_x + ox), clamp_pos(goal_y + oy),
                             $signed(16'($urandom)), $signed(16'($urandom)),
                             $signed(16'($urandom)), $signed(16'($urandom)));
        end
        return make_pose(clamp_pos(goal_x + ox), clamp_pos(goal_y + oy),
                         longint'($urandom_range(0, 400)) - 200,
                         longint'($urandom_range(0, 400)) - 200,
                         $signed(16'($urandom)), $signed(16'($urandom)));
    endfunction

    function automatic pose_t wild_pose();
        return make_pose($signed(28'($urandom)), $signed(28'($urandom)),
                         $signed(16'($urandom)), $signed(16'($urandom)),
                         $signed(16'($urandom)), $signed(16'($urandom)));
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        steer_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result speed=%0d turn=%0d reached=%0d", $time,
                         m_linear_speed, m_turn_rate, m_goal_reached);
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                if (m_linear_speed !== want.speed) begin
                    $display("%0t: linear_speed expected %0d actual %0d", $time,
                             want.speed, m_linear_speed);
                    errors++;
                end
                if (m_turn_rate !== want.turn) begin
                    $display("%0t: turn_rate expected %0d actual %0d", $time,
                             want.turn, m_turn_rate);
                    errors++;
                end
                if (m_goal_reached !== want.reached) begin
                    $display("%0t: goal_reached expected %0d actual %0d", $time,
                             want.reached, m_goal_reached);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern: modes of steady, random, sparse and periodic readiness.
    always @(posedge aclk) begin
        int mode;
        if (cycles % 97 == 0) mode = $urandom_range(0, 3);
        case (mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            2:       m_ready <= ($urandom_range(0, 5) == 0);
            default: m_ready <= (cycles % 11) < 6;
        endcase
    end

    // Poses taken before any goal is written produce nothing.
    task automatic test_unarmed();
        repeat (3) send_pose(wild_pose());
        idle_sender();
        wait_drained();
    endtask

    // Field extremes against a goal at the origin.
    task automatic test_extremes();
        write_reg(REG_GOAL_X, 0);
        write_reg(REG_ARRIVE_RAD, 0);
        send_pose(make_pose(POS_HI, POS_HI, 32767, 32767, 32767, 32767));
        send_pose(make_pose(POS_LO, POS_LO, -32768, -32768, -32768, -32768));
        send_pose(make_pose(POS_LO, POS_HI, 0, 0, 32767, -32768));
        send_pose(make_pose(65536, -65536, 0, 0, -32768, 0));
        idle_sender();
        wait_drained();
        write_reg(REG_MAX_SPEED, 262144);
        write_reg(REG_HEAD_LIMIT, 205887);
        send_pose(make_pose(POS_HI, 0, 0, 0, 0, 32767));
        send_pose(make_pose(300000, 200000, 0, 0, 23170, 23170));
        idle_sender();
        wait_drained();
        write_reg(REG_MAX_SPEED, 0);
        write_reg(REG_HEAD_LIMIT, 0);
        send_pose(make_pose(300000, 200000, 0, 0, 23170, 23170));
        idle_sender();
        wait_drained();
    endtask

    // Degenerate quaternions force yaw to zero.
    task automatic test_degenerate_quat();
        write_reg(REG_MAX_SPEED, 32768);
        write_reg(REG_HEAD_LIMIT, 32768);
        send_pose(make_pose(-200000, 100000, 0, 0, 0, 0));
        send_pose(make_pose(-200000, 100000, 16384, 0, 16384, 0));
        send_pose(make_pose(-200000, 100000, 0, 20000, 0, -20000));
        idle_sender();
        wait_drained();
    endtask

    // Heading error near the wrap point, goal behind the robot.
    task automatic test_heading_wrap();
        write_reg(REG_GOAL_X, -655360);
        write_reg(REG_GOAL_Y, 1);
        send_pose(make_pose(0, 0, 0, 0, 0, 32767));
        send_pose(make_pose(0, 0, 0, 0, 32767, 100));
        send_pose(make_pose(0, 0, 0, 0, 32767, -100));
        idle_sender();
        wait_drained();
    endtask

    // Obstacle on the robot with a huge radius rejects every sample.
    task automatic test_all_blocked();
        write_reg(REG_OBS_X, 0);
        write_reg(REG_OBS_Y, 0);
        write_reg(REG_OBS_RADIUS, 1048576);
        send_pose(make_pose(0, 0, 0, 0, 0, 32767));
        send_pose(make_pose(30000, -20000, 0, 0, 12000, 30000));
        idle_sender();
        wait_drained();
        write_reg(REG_OBS_RADIUS, 0);
        send_pose(make_pose(0, 0, 0, 0, 0, 32767));
        idle_sender();
        wait_drained();
    endtask

    // Arrival disarms; the next pose is ignored until a goal is rewritten.
    task automatic test_arrival();
        write_reg(REG_ARRIVE_RAD, 1048576);
        write_reg(REG_GOAL_Y, 65536);
        send_pose(make_pose(-655360, 65536, 0, 0, 0, 32767));
        send_pose(make_pose(-655360, 0, 0, 0, 0, 32767));
        send_pose(make_pose(0, 0, 0, 0, 0, 32767));
        idle_sender();
        wait_drained();
        write_reg(REG_ARRIVE_RAD, 0);
        write_reg(REG_GOAL_Y, 65536);
        send_pose(make_pose(-655360, 65536, 0, 0, 0, 32767));
        idle_sender();
        wait_drained();
        write_reg(REG_ARRIVE_RAD, 6554);
    endtask

    // Random setup between phases; extremes come up now and then.
    task automatic randomize_setup();
        longint span;
        span = ($urandom_range(0, 5) == 0) ? 134217727 : 2000000;
        write_reg(REG_GOAL_X, ($urandom_range(0, 7) == 0) ? $urandom :
                  longint'($urandom_range(0, 2 * span)) - span);
        write_reg(REG_GOAL_Y, ($urandom_range(0, 7) == 0) ? $urandom :
                  longint'($urandom_range(0, 2 * span)) - span);
        write_reg(REG_OBS_X, ($urandom_range(0, 3) == 0) ? $urandom :
                  goal_x + longint'($urandom_range(0, 400000)) - 200000);
        write_reg(REG_OBS_Y, ($urandom_range(0, 3) == 0) ? $urandom :
                  goal_y + longint'($urandom_range(0, 400000)) - 200000);
        case ($urandom_range(0, 3))
            0:       write_reg(REG_MAX_SPEED, 0);
            1:       write_reg(REG_MAX_SPEED, 262144);
            2:       write_reg(REG_MAX_SPEED, $urandom);
            default: write_reg(REG_MAX_SPEED, $urandom_range(0, 262144));
        endcase
        write_reg(REG_OBS_RADIUS, ($urandom_range(0, 4) == 0) ? $urandom :
                  $urandom_range(0, 150000));
        write_reg(REG_HEAD_LIMIT, ($urandom_range(0, 4) == 0) ? $urandom :
                  $urandom_range(0, 205887));
        write_reg(REG_ARRIVE_RAD, ($urandom_range(0, 4) == 0) ? $urandom :
                  $urandom_range(0, 120000));
    endtask

    // Random phases: mostly poses around the goal, some anywhere.
    task automatic test_random();
        int sent;
        int group;
        longint span;
        sent = 0;
        while (sent < 267) begin
            randomize_setup();
            group = $urandom_range(8, 24);
            for (int i = 0; i < group; i++) begin
                if (!armed && $urandom_range(0, 1) == 0) break;
                span = ($urandom_range(0, 2) == 0) ? 100000 : 1500000;
                send_pose(($urandom_range(0, 9) == 0) ? wild_pose() : near_pose(span));
                sent++;
            end
            idle_sender();
            wait_drained();
        end
    endtask

    // Test sequence.
    initial begin
        goal_x = 0; goal_y = 0;
        obst_x = -6553600; obst_y = -6553600;
        speed_cap = 32768; obst_radius = 65536;
        head_limit = 32768; arrive_rad = 6554;
        armed = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_unarmed();
        test_extremes();
        test_degenerate_quat();
        test_heading_wrap();
        test_all_blocked();
        test_arrival();
        test_random();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/stg_pkg.sv
rtl/stg_regs.sv
rtl/stg_isqrt.sv
rtl/stg_cordic.sv
rtl/sampled_turn_rate_goal_steering.sv
verif/sampled_turn_rate_goal_steering_tb.sv
